### hw/rtl/lsd2_pkg.sv
// ----------------------------------------------------------------------------
// lsd2_pkg
// Shared types and codes of the limb stream divider: the command set that
// the front end hands to the back end, the stream phase and the back-end
// state, and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd2_pkg;

  // Commands carried through the queue from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_ZERO = 3'd0, // emit an all-zero top quotient limb, clear the remainder
    CMD_BAD  = 3'd1, // emit the error result of a one-limb dividend
    CMD_LOAD = 3'd2, // load the remainder from the operand, no result
    CMD_CMP  = 3'd3, // compare-subtract the two-limb operand, emit one quotient bit
    CMD_DIV  = 3'd4, // bit-serial 3-by-2 division step, emit one quotient limb
    CMD_REM  = 3'd5  // emit the shifted remainder, end of dividend
  } lsd2_cmd_e;

  // Position of the front end within a dividend.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2
  } lsd2_phase_e;

  // Back-end execution state.
  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } lsd2_back_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DIV_HIGH = 2'd0;
  localparam logic [1:0] CFG_DIV_LOW  = 2'd1;
  localparam logic [1:0] CFG_RECIP    = 2'd2;
  localparam logic [1:0] CFG_SHIFT    = 2'd3;

endpackage

`default_nettype wire

### hw/rtl/lsd2_front.sv
// ----------------------------------------------------------------------------
// lsd2_front
// Accepts dividend limbs, tracks the stream phase and the previous limb,
// applies the normalization shift and turns each limb into at most three
// commands that it pushes into the queue one per cycle while it is not full.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd2_front import lsd2_pkg::*; #(
  parameter int LB = 32,
  parameter int SW = 5,
  parameter int CW = 3 + 2 * LB
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   limb_i,
  input  wire logic          is_first_i,
  input  wire logic          is_last_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [SW-1:0] shift_i,
  output logic               push_o,
  output logic [CW-1:0]      push_data_o,
  input  wire logic          full_i
);

  localparam int AW = 2 * LB;

  lsd2_phase_e   phase_q, phase_d;
  logic [LB-1:0] prev_q, prev_d;
  logic [CW-1:0] slot_q [3];
  logic [CW-1:0] new_cmd [3];
  logic [1:0]    pend_q, n_new;
  logic          accept;
  logic [LB-1:0] limb;
  logic [3*LB-1:0] x;

  assign limb       = limb_i[LB-1:0];
  assign in_stall_o = (pend_q != 2'd0);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (pend_q != 2'd0) && !full_i;
  assign push_data_o = slot_q[0];

  // Previous and current limb shifted left across the limb border.
  assign x = {{LB{1'b0}}, prev_q, limb} << shift_i;

  always_comb begin
    phase_d    = phase_q;
    prev_d     = prev_q;
    n_new      = 2'd0;
    new_cmd[0] = '0;
    new_cmd[1] = '0;
    new_cmd[2] = '0;
    if (accept) begin
      priority if (is_first_i && is_last_i) begin
        new_cmd[0] = {CMD_BAD, {AW{1'b0}}};
        n_new      = 2'd1;
        phase_d    = PH_IDLE;
      end else if (is_first_i) begin
        new_cmd[0] = {CMD_ZERO, {AW{1'b0}}};
        n_new      = 2'd1;
        prev_d     = limb;
        phase_d    = PH_SECOND;
      end else if (phase_q != PH_IDLE) begin
        prev_d  = limb;
        phase_d = PH_BODY;
        n_new   = 2'd1;
        if (phase_q == PH_SECOND) begin
          if (shift_i != '0) begin
            new_cmd[0] = {CMD_LOAD, x[3*LB-1:LB]};
          end else begin
            new_cmd[0] = {CMD_CMP, prev_q, limb};
          end
        end else begin
          if (shift_i != '0) begin
            new_cmd[0] = {CMD_DIV, {LB{1'b0}}, x[2*LB-1:LB]};
          end else begin
            new_cmd[0] = {CMD_DIV, {LB{1'b0}}, limb};
          end
        end
        if (is_last_i) begin
          phase_d = PH_IDLE;
          if (shift_i != '0) begin
            // One more division brings in the bits shifted out of the last limb.
            new_cmd[1] = {CMD_DIV, {LB{1'b0}}, x[LB-1:0]};
            new_cmd[2] = {CMD_REM, {AW{1'b0}}};
            n_new      = 2'd3;
          end else begin
            new_cmd[1] = {CMD_REM, {AW{1'b0}}};
            n_new      = 2'd2;
          end
        end
      end else begin
        n_new = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prev_q  <= '0;
      pend_q  <= 2'd0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      if (accept) begin
        pend_q <= n_new;
      end else if (push_o) begin
        pend_q <= pend_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[0] <= new_cmd[0];
      slot_q[1] <= new_cmd[1];
      slot_q[2] <= new_cmd[2];
    end else if (push_o) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lsd2_fifo.sv
// ----------------------------------------------------------------------------
// lsd2_fifo
// Four-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd2_fifo #(
  parameter int DW = 67
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [DW-1:0]      pop_data_o
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == (PW + 1)'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lsd2_back.sv
// ----------------------------------------------------------------------------
// lsd2_back
// Executes queued commands against the running two-limb remainder. Divisions
// run on a restoring unit that retires one quotient bit per cycle, but the final
// bit waits for a free output register. Results leave through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd2_back import lsd2_pkg::*; #(
  parameter int LB = 32,
  parameter int SW = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire lsd2_cmd_e       cmd_op_i,
  input  wire logic [2*LB-1:0] cmd_arg_i,
  output logic                 cmd_pop_o,
  input  wire logic [LB-1:0]   div_high_i,
  input  wire logic [LB-1:0]   div_low_i,
  input  wire logic [SW-1:0]   shift_i,
  output logic [31:0]          quotient_limb_o,
  output logic [63:0]          remainder_o,
  output logic                 is_remainder_o,
  output logic                 last_o,
  output logic                 bad_length_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i
);

  localparam int CNW = $clog2(LB);

  lsd2_back_e     state_q, state_d;
  logic [2*LB-1:0] rem_q, rem_d;
  logic [LB-1:0]  u_q, u_d, q_q, q_d;
  logic [CNW-1:0] cnt_q, cnt_d;

  logic [2*LB-1:0] dvs, sh, r_step, cmp_diff;
  logic           take, cmp_take, out_free, load_out, out_valid_q, out_valid_d;
  logic [LB-1:0]  q_step;

  logic [31:0]    o_quot_q, o_quot_d;
  logic [63:0]    o_rem_q, o_rem_d;
  logic           o_isrem_q, o_isrem_d, o_last_q, o_last_d, o_bad_q, o_bad_d;

  assign dvs = {div_high_i, div_low_i};

  // One restoring step; the bit shifted out of the top forces a subtract.
  assign sh       = {rem_q[2*LB-2:0], u_q[LB-1]};
  assign take     = rem_q[2*LB-1] || (sh >= dvs);
  assign r_step   = take ? (sh - dvs) : sh;
  assign q_step   = {q_q[LB-2:0], take};
  assign cmp_take = (cmd_arg_i >= dvs);
  assign cmp_diff = cmd_arg_i - dvs;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    u_d       = u_q;
    q_d       = q_q;
    cnt_d     = cnt_q;
    cmd_pop_o = 1'b0;
    load_out  = 1'b0;
    o_quot_d  = '0;
    o_rem_d   = '0;
    o_isrem_d = 1'b0;
    o_last_d  = 1'b0;
    o_bad_d   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_op_i)
            CMD_ZERO: begin
              rem_d    = '0;
              load_out = 1'b1;
            end
            CMD_BAD: begin
              load_out = 1'b1;
              o_last_d = 1'b1;
              o_bad_d  = 1'b1;
            end
            CMD_LOAD: begin
              rem_d = cmd_arg_i;
            end
            CMD_CMP: begin
              rem_d    = cmp_take ? cmp_diff : cmd_arg_i;
              load_out = 1'b1;
              o_quot_d = {31'd0, cmp_take};
            end
            CMD_DIV: begin
              u_d     = cmd_arg_i[LB-1:0];
              q_d     = '0;
              cnt_d   = CNW'(LB - 1);
              state_d = BK_DIV;
            end
            CMD_REM: begin
              load_out  = 1'b1;
              o_rem_d   = 64'(rem_q >> shift_i);
              o_isrem_d = 1'b1;
              o_last_d  = 1'b1;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_DIV: begin
        if (cnt_q != '0) begin
          rem_d = r_step;
          q_d   = q_step;
          u_d   = {u_q[LB-2:0], 1'b0};
          cnt_d = cnt_q - 1'b1;
        end else if (out_free) begin
          // The final step waits here until the output register is free.
          rem_d    = r_step;
          load_out = 1'b1;
          o_quot_d = 32'(q_step);
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    out_valid_d = load_out ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    q_q   <= q_d;
    cnt_q <= cnt_d;
    if (load_out) begin
      o_quot_q  <= o_quot_d;
      o_rem_q   <= o_rem_d;
      o_isrem_q <= o_isrem_d;
      o_last_q  <= o_last_d;
      o_bad_q   <= o_bad_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign quotient_limb_o = o_quot_q;
  assign remainder_o     = o_rem_q;
  assign is_remainder_o  = o_isrem_q;
  assign last_o          = o_last_q;
  assign bad_length_o    = o_bad_q;

endmodule

`default_nettype wire

### hw/rtl/limb_stream_divider_by_two_limb.sv
// Each body limb runs a division in the bit-serial restoring unit of the back
//   end; the front end takes a new limb only once it has pushed every command
//   of the previous one.
// Reset (rst_ni low, asynchronous): phase, queue and output valid clear, and
//   the configuration registers return to their reset values.
// ----------------------------------------------------------------------------
// limb_stream_divider_by_two_limb
// Streaming division of a multi-limb dividend by a normalized two-limb divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module limb_stream_divider_by_two_limb import lsd2_pkg::*; #(
  parameter int LIMB_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Input channel: one dividend limb per transaction.
  input  wire logic [31:0] limb_i,
  input  wire logic        is_first_i,
  input  wire logic        is_last_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  // Output channel: one quotient limb or the remainder per transaction.
  output logic [31:0]      quotient_limb_o,
  output logic [63:0]      remainder_o,
  output logic             is_remainder_o,
  output logic             last_o,
  output logic             bad_length_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i
);

  localparam int LB  = LIMB_BITS;
  localparam int SW  = $clog2(LB);
  localparam int OPW = $bits(lsd2_cmd_e);
  localparam int CW  = OPW + 2 * LB;

  // Configuration registers. The reciprocal (index 2) is accepted and dropped:
  // the restoring unit works from the divisor alone, exact if it is normalized.
  logic [LB-1:0] div_high_q, div_low_q;
  logic [4:0]    shift_q;
  logic [SW-1:0] shift_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_high_q <= LB'(32'h8000_0000);
      div_low_q  <= '0;
      shift_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIV_HIGH: div_high_q <= cfg_wdata_i[LB-1:0];
        CFG_DIV_LOW:  div_low_q  <= cfg_wdata_i[LB-1:0];
        CFG_RECIP:    ;
        CFG_SHIFT:    shift_q    <= cfg_wdata_i[4:0];
        default:      ;
      endcase
    end
  end

  // A shift of the limb width or more acts as the widest legal shift.
  assign shift_eff = (shift_q > 5'(LB - 1)) ? SW'(LB - 1) : shift_q[SW-1:0];

  logic          push, full, empty, pop;
  logic [CW-1:0] push_data, pop_data;

  // The front end decodes each limb into commands for the back end.
  lsd2_front #(
    .LB (LB),
    .SW (SW),
    .CW (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limb_i      (limb_i),
    .is_first_i  (is_first_i),
    .is_last_i   (is_last_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .shift_i     (shift_eff),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // The queue lets the front end keep taking limbs while a division runs.
  lsd2_fifo #(
    .DW (CW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  // The back end owns the running remainder and the output register.
  lsd2_back #(
    .LB (LB),
    .SW (SW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (!empty),
    .cmd_op_i        (lsd2_cmd_e'(pop_data[CW-1 -: OPW])),
    .cmd_arg_i       (pop_data[2*LB-1:0]),
    .cmd_pop_o       (pop),
    .div_high_i      (div_high_q),
    .div_low_i       (div_low_q),
    .shift_i         (shift_eff),
    .quotient_limb_o (quotient_limb_o),
    .remainder_o     (remainder_o),
    .is_remainder_o  (is_remainder_o),
    .last_o          (last_o),
    .bad_length_o    (bad_length_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule

`default_nettype wire

### tb/limb_stream_divider_by_two_limb_tb.sv
// ----------------------------------------------------------------------------
// limb_stream_divider_by_two_limb_tb
// Self-checking bench for the limb stream divider: a directed table followed
// by randomized dividends under several divisor and shift settings. Every
// result is checked against typed values or the in-bench bit-exact predictor.
// ----------------------------------------------------------------------------
module limb_stream_divider_by_two_limb_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsd2_pkg::*;

  localparam int LIMB_BITS = 32;
  localparam time CLK_PERIOD = 10ns;
  localparam int RESET_CYCLES = 11;
  // Quiet time that lets anything still in flight that produces no result drain out.
  localparam int QUIET_CYCLES = 2 * (LIMB_BITS + 3);
  // Longest stretch without any accepted transaction in a correct run is the
  // long receiver hold plus the divisions still queued; the limit is far above.
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 42;
  localparam int HOLD_PHASE = 4;

  // One output transaction of the block.
  typedef struct packed {
    logic [31:0] quotient;
    logic [63:0] remainder;
    logic        is_rem;
    logic        last;
    logic        bad;
  } quot_result_t;

  // How the expected results of a stimulus row are obtained: typed in directly
  // where they are obvious, none where the row gives no result, otherwise taken from the predictor.
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_TOP_ZERO,
    CHK_BAD_LENGTH
  } check_e;

  typedef enum logic {
    ROW_LIMB,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    check_e      chk;
    logic [1:0]  index;
    logic [31:0] data;
    logic        first;
    logic        last;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;
  logic [31:0] limb_i;
  logic        is_first_i;
  logic        is_last_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] quotient_limb_o;
  logic [63:0] remainder_o;
  logic        is_remainder_o;
  logic        last_o;
  logic        bad_length_o;
  logic        out_valid_o;
  logic        out_stall_i;

  // Predictor copy of the configuration registers, at their reset values.
  logic [31:0] cfg_div_high = 32'h8000_0000;
  logic [31:0] cfg_div_low = 32'h0;
  logic [31:0] cfg_recip = 32'hFFFF_FFFF;
  logic [4:0]  cfg_shift = 5'd0;

  // Predictor copy of the running division state.
  logic [31:0]  rem_high = 32'h0;
  logic [31:0]  rem_mid = 32'h0;
  logic [31:0]  prev_limb = 32'h0;
  lsd2_phase_e  div_phase = PH_IDLE;

  quot_result_t pending_quotients[$];
  stim_row_t    directed_rows[$];
  int           mismatches = 0;
  int           hold_cycles = 0;
  bit           feed_eager = 1'b0;
  bit           sink_eager = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  limb_stream_divider_by_two_limb #(
    .LIMB_BITS(LIMB_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .limb_i         (limb_i),
    .is_first_i     (is_first_i),
    .is_last_i      (is_last_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .quotient_limb_o(quotient_limb_o),
    .remainder_o    (remainder_o),
    .is_remainder_o (is_remainder_o),
    .last_o         (last_o),
    .bad_length_o   (bad_length_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic quot_result_t make_result(input logic [31:0] quotient,
                                               input logic [63:0] remainder,
                                               input logic is_rem, input logic last,
                                               input logic bad);
    quot_result_t res;
    res.quotient = quotient;
    res.remainder = remainder;
    res.is_rem = is_rem;
    res.last = last;
    res.bad = bad;
    return res;
  endfunction

  // Restoring division of (rem_high:rem_mid:u0) by the two-limb divisor, one
  // quotient bit per step. The bit shifted out of the top of the remainder
  // forces a subtraction, which keeps the step exact for a normalized divisor
  // and deterministic for any other one. The remainder is written back.
  function automatic logic [31:0] divide_3by2(input logic [31:0] u0);
    logic [63:0] divisor;
    logic [63:0] rem;
    logic [31:0] quot;
    logic        carry;
    divisor = {cfg_div_high, cfg_div_low};
    rem = {rem_high, rem_mid};
    quot = '0;
    for (int i = LIMB_BITS - 1; i >= 0; i--) begin
      carry = rem[63];
      rem = {rem[62:0], u0[i]};
      quot = {quot[30:0], 1'b0};
      if (carry || rem >= divisor) begin
        rem = rem - divisor;
        quot[0] = 1'b1;
      end
    end
    {rem_high, rem_mid} = rem;
    return quot;
  endfunction

  // Advances the predictor by one accepted limb and returns how many result
  // transactions that limb causes; the results land in res[0 .. n-1].
  function automatic int advance_division(input logic [31:0] value, input logic first,
                                          input logic fin, output quot_result_t [2:0] res);
    int          n;
    logic [95:0] wide;
    logic [63:0] rem;
    logic        quot_bit;
    n = 0;
    res = '0;
    // Dividend limbs shifted left across the limb border by the shift amount.
    wide = {32'h0, prev_limb, value} << cfg_shift;
    if (first) begin
      if (fin) begin
        res[0] = make_result('0, '0, 1'b0, 1'b1, 1'b1);
        div_phase = PH_IDLE;
      end else begin
        prev_limb = value;
        rem_high = '0;
        rem_mid = '0;
        div_phase = PH_SECOND;
        res[0] = make_result('0, '0, 1'b0, 1'b0, 1'b0);
      end
      return 1;
    end
    if (div_phase == PH_IDLE) begin
      return 0;
    end
    if (div_phase == PH_SECOND) begin
      if (cfg_shift != 0) begin
        {rem_high, rem_mid} = wide[95:32];
      end else begin
        // Without a shift the top two limbs may exceed the divisor once.
        rem = {prev_limb, value};
        quot_bit = 1'b0;
        if (rem >= {cfg_div_high, cfg_div_low}) begin
          rem = rem - {cfg_div_high, cfg_div_low};
          quot_bit = 1'b1;
        end
        {rem_high, rem_mid} = rem;
        res[n] = make_result({31'h0, quot_bit}, '0, 1'b0, 1'b0, 1'b0);
        n++;
      end
      prev_limb = value;
      div_phase = PH_BODY;
    end else begin
      prev_limb = value;
      res[n] = make_result(divide_3by2((cfg_shift != 0) ? wide[63:32] : value), '0,
                           1'b0, 1'b0, 1'b0);
      n++;
    end
    if (fin) begin
      // A shifted dividend has one more limb: the low bits shifted out.
      if (cfg_shift != 0) begin
        res[n] = make_result(divide_3by2(prev_limb << cfg_shift), '0, 1'b0, 1'b0, 1'b0);
        n++;
      end
      res[n] = make_result('0, {rem_high, rem_mid} >> cfg_shift, 1'b1, 1'b1, 1'b0);
      n++;
      div_phase = PH_IDLE;
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [31:0] random_limb();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 15));
      3: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Register writes happen only while the block is idle, so the predictor
  // copy is updated right away.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      CFG_DIV_HIGH: cfg_div_high = data;
      CFG_DIV_LOW:  cfg_div_low = data;
      CFG_RECIP:    cfg_recip = data;
      CFG_SHIFT:    cfg_shift = data[4:0];
      default: ;
    endcase
  endtask

  // Offers one limb after a random gap and holds it until the block takes it.
  // The gap is skipped during eager stretches, so back-to-back transactions
  // keep valid high without a glitch.
  task automatic send_limb(input logic [31:0] value, input logic first, input logic fin,
                           input check_e chk);
    int                   gap;
    int                   n;
    quot_result_t [2:0]   step_res;
    gap = feed_eager ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 29) == 0) begin
      feed_eager = !feed_eager;
    end
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    limb_i <= value;
    is_first_i <= first;
    is_last_i <= fin;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    // The predictor always advances; typed rows only replace its results.
    n = advance_division(value, first, fin, step_res);
    case (chk)
      CHK_PREDICT: begin
        for (int i = 0; i < n; i++) begin
          pending_quotients.push_back(step_res[i]);
        end
      end
      CHK_TOP_ZERO: pending_quotients.push_back(make_result('0, '0, 1'b0, 1'b0, 1'b0));
      CHK_BAD_LENGTH: pending_quotients.push_back(make_result('0, '0, 1'b0, 1'b1, 1'b1));
      default: ;
    endcase
  endtask

  // Drops valid, waits for every expected result and then lets any result-free
  // work, such as a pending remainder load, drain out of the block.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed dividends with random content. The rest are one-limb
  // dividends, stray limbs outside a dividend and dividends cut off before
  // their last limb, which the next first limb then restarts. Stray limbs are
  // not counted.
  task automatic send_random_dividend(output int counted);
    int style;
    int len;
    int stop;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      send_limb(random_limb(), 1'b1, 1'b1, CHK_PREDICT);
      counted = 1;
    end else begin
      if (style == 1) begin
        repeat ($urandom_range(1, 2)) send_limb(random_limb(), 1'b0, 1'b0, CHK_PREDICT);
      end
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(2, 5);
      stop = (style == 2) ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < stop; i++) begin
        send_limb(random_limb(), i == 0, i == len - 1, CHK_PREDICT);
      end
      counted = stop;
    end
  endtask

  task automatic add_limb_row(input check_e chk, input logic [31:0] data,
                              input logic first, input logic last);
    stim_row_t row;
    row = '0;
    row.kind = ROW_LIMB;
    row.chk = chk;
    row.data = data;
    row.first = first;
    row.last = last;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg_row(input logic [1:0] index, input logic [31:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.chk = CHK_NONE;
    row.index = index;
    row.data = data;
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, with eager stretches and one long hold.
  // --------------------------------------------------------------------------

  initial begin : result_sink
    int wait_cycles;
    out_stall_i = 1'b0;
    forever begin
      if (hold_cycles != 0) begin
        // Long hold-off so that the block fills up and stalls its input.
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else if (sink_eager) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 15);
      end
      if ($urandom_range(0, 29) == 0) begin
        sink_eager = !sink_eager;
      end
      if (wait_cycles != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (wait_cycles - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Each accepted result transaction is compared with the oldest expectation.
  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    quot_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_quotients.size() == 0) begin
        $error("unexpected result: quotient_limb %h remainder %h is_remainder %b",
               quotient_limb_o, remainder_o, is_remainder_o);
        mismatches++;
      end else begin
        want = pending_quotients.pop_front();
        check_field("quotient_limb", 64'(want.quotient), 64'(quotient_limb_o));
        check_field("remainder", want.remainder, remainder_o);
        check_field("is_remainder", 64'(want.is_rem), 64'(is_remainder_o));
        check_field("last", 64'(want.last), 64'(last_o));
        check_field("bad_length", 64'(want.bad), 64'(bad_length_o));
      end
    end
  end

  // Watchdog: ends the run when no transaction is accepted on either side for
  // too long, which covers a hung block as well as missing results.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("limb_stream_divider_by_two_limb_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : main_sequence
    int          sent;
    int          n;
    logic [31:0] div_high;
    logic [31:0] div_low;
    logic [31:0] recip;
    logic [31:0] shift_junk;
    logic [4:0]  shift;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_DIV_HIGH;
    cfg_wdata_i = '0;
    limb_i = '0;
    is_first_i = 1'b0;
    is_last_i = 1'b0;
    in_valid_i = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Rows run at the reset configuration first: a limb with
    // no dividend open is ignored, a one-limb dividend is an error, and the
    // first limb of a longer dividend always yields a zero top quotient limb.
    add_limb_row(CHK_NONE,       32'h1234_5678, 1'b0, 1'b0);
    add_limb_row(CHK_BAD_LENGTH, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_limb_row(CHK_TOP_ZERO,   32'hFFFF_FFFF, 1'b1, 1'b0);
    add_limb_row(CHK_PREDICT,    32'hFFFF_FFFF, 1'b0, 1'b0);
    add_limb_row(CHK_PREDICT,    32'h0000_0000, 1'b0, 1'b1);
    add_limb_row(CHK_TOP_ZERO,   32'h0000_0000, 1'b1, 1'b0);
    add_limb_row(CHK_PREDICT,    32'h0000_0000, 1'b0, 1'b1);
    // A new first limb drops the open dividend without a remainder.
    add_limb_row(CHK_TOP_ZERO,   32'hDEAD_BEEF, 1'b1, 1'b0);
    add_limb_row(CHK_PREDICT,    32'hFFFF_FFFF, 1'b0, 1'b0);
    add_limb_row(CHK_TOP_ZERO,   32'h8000_0000, 1'b1, 1'b0);
    add_limb_row(CHK_PREDICT,    32'h0000_0001, 1'b0, 1'b0);
    add_limb_row(CHK_PREDICT,    32'h8000_0000, 1'b0, 1'b1);
    // Largest divisor with the largest shift. With a shift the second limb only
    // loads the remainder, and the last limb adds one extra quotient limb.
    add_cfg_row(CFG_DIV_HIGH, 32'hFFFF_FFFF);
    add_cfg_row(CFG_DIV_LOW,  32'hFFFF_FFFF);
    add_cfg_row(CFG_SHIFT,    32'd31);
    add_cfg_row(CFG_RECIP,    32'h0);
    add_limb_row(CHK_TOP_ZERO,   32'hFFFF_FFFF, 1'b1, 1'b0);
    add_limb_row(CHK_PREDICT,    32'hFFFF_FFFF, 1'b0, 1'b1);
    add_limb_row(CHK_TOP_ZERO,   32'h8000_0000, 1'b1, 1'b0);
    add_limb_row(CHK_NONE,       32'h1234_5678, 1'b0, 1'b0);
    add_limb_row(CHK_PREDICT,    32'hFFFF_FFFF, 1'b0, 1'b0);
    add_limb_row(CHK_PREDICT,    32'h0000_0000, 1'b0, 1'b1);
    // Zero divisor: results are deterministic, quotient limbs all ones.
    add_cfg_row(CFG_DIV_HIGH, 32'h0);
    add_cfg_row(CFG_DIV_LOW,  32'h0);
    add_cfg_row(CFG_SHIFT,    32'd1);
    add_limb_row(CHK_TOP_ZERO,   32'h0000_0007, 1'b1, 1'b0);
    add_limb_row(CHK_NONE,       32'h0000_0009, 1'b0, 1'b0);
    add_limb_row(CHK_PREDICT,    32'hFFFF_0000, 1'b0, 1'b1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_limb(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                  directed_rows[i].chk);
      end
    end

    // Random part: a new configuration per phase, the first few at the
    // extremes, then random and occasionally unnormalized divisors, whose shift
    // writes carry random upper bits, which the register must discard.
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_block();
      shift_junk = '0;
      case (p)
        0: begin
          div_high = 32'h8000_0000;
          div_low = 32'h0;
          recip = 32'hFFFF_FFFF;
          shift = 5'd0;
        end
        1: begin
          div_high = 32'hFFFF_FFFF;
          div_low = 32'hFFFF_FFFF;
          recip = 32'h0;
          shift = 5'd31;
        end
        2: begin
          div_high = 32'h8000_0000;
          div_low = 32'hFFFF_FFFF;
          recip = $urandom;
          shift = 5'd16;
        end
        default: begin
          div_high = ($urandom_range(0, 7) == 0) ? $urandom : ($urandom | 32'h8000_0000);
          div_low = $urandom;
          recip = $urandom;
          shift = 5'($urandom_range(0, 31));
          shift_junk = $urandom;
        end
      endcase
      write_reg(CFG_DIV_HIGH, div_high);
      write_reg(CFG_DIV_LOW, div_low);
      write_reg(CFG_RECIP, recip);
      write_reg(CFG_SHIFT, {shift_junk[31:5], shift});
      if (p == HOLD_PHASE) begin
        hold_cycles = HOLD_CYCLES;
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_random_dividend(n);
        sent += n;
      end
    end

    settle_block();
    if (mismatches == 0 && pending_quotients.size() == 0) begin
      $display("limb_stream_divider_by_two_limb_tb passed");
    end else begin
      $display("limb_stream_divider_by_two_limb_tb failed");
    end
    $finish;
  end

endmodule
